// ===== hdl/psd_pkg.sv =====
// Shared types and constants for the particle step and depth plot block.
package psd_pkg;

    localparam int PARTICLES  = 1024;
    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int STORE_AW   = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int PART_AW    = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int SWEEP_LEN  = (STORE_SIZE > PARTICLES) ? STORE_SIZE : PARTICLES;
    localparam int SWEEP_W    = (SWEEP_LEN > 1) ? $clog2(SWEEP_LEN) : 1;

    localparam int EPOCH_W = 8;

    localparam int IN_W       = 128;
    localparam int OUT_W      = 80;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_STEP  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPAWN_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPAWN_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPAWN_Z       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPAWN_VX      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPAWN_VY_GAIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPAWN_VZ_GAIN = 3'd7;

    localparam logic signed [31:0] SLOW_LIMIT = 32'sh0000_1000;
    localparam logic [31:0]        GRAVITY    = 32'h0000_0800;

    // Q16.16 particle, x in the lowest bits
    typedef struct packed {
        logic [31:0] vz;
        logic [31:0] vy;
        logic [31:0] vx;
        logic [31:0] pz;
        logic [31:0] py;
        logic [31:0] px;
    } particle_t;

    typedef struct packed {
        logic [23:0] spawn_vz_gain;
        logic [23:0] spawn_vy_gain;
        logic [23:0] spawn_vx;
        logic [23:0] spawn_z;
        logic [22:0] spawn_y;
        logic [22:0] spawn_x;
        logic [7:0]  image_height;
        logic [7:0]  image_width;
    } cfg_t;

endpackage

// ===== hdl/psd_respawn.sv =====
// Respawn: emitter position and vx plus signed jitter; vy, vz gain * jitter.
module psd_respawn (
    input  logic               clk,
    input  psd_pkg::cfg_t      cfg,
    input  logic [63:0]        rand_lo,
    input  logic [31:0]        rand_hi,
    output psd_pkg::particle_t spawn
);
    import psd_pkg::*;

    function automatic logic [31:0] apply_sign(input logic [31:0] v, input logic neg);
        return neg ? (32'd0 - v) : v;
    endfunction

    logic [14:0] m0, m1, m2, m3, m4, m5;
    logic        n0, n1, n2, n3, n4, n5;
    logic        vy_neg, vz_neg;
    logic [23:0] vy_mag, vz_mag;

    logic [21:0] px_prod_reg;
    logic [22:0] vy_prod_reg;
    logic [23:0] vz_prod_reg;

    // each slice: bit 15 sign, bits 14..0 magnitude
    assign m0 = rand_lo[14:0];
    assign n0 = rand_lo[15];
    assign m1 = rand_lo[30:16];
    assign n1 = rand_lo[31];
    assign m2 = rand_lo[46:32];
    assign n2 = rand_lo[47];
    assign m3 = rand_lo[62:48];
    assign n3 = rand_lo[63];
    assign m4 = rand_hi[14:0];
    assign n4 = rand_hi[15];
    assign m5 = rand_hi[30:16];
    assign n5 = rand_hi[31];

    // gains are scaled as magnitudes so the shift truncates toward zero
    assign vy_neg = cfg.spawn_vy_gain[23];
    assign vz_neg = cfg.spawn_vz_gain[23];
    assign vy_mag = vy_neg ? (24'd0 - cfg.spawn_vy_gain) : cfg.spawn_vy_gain;
    assign vz_mag = vz_neg ? (24'd0 - cfg.spawn_vz_gain) : cfg.spawn_vz_gain;

    always_ff @(posedge clk)
    begin
        px_prod_reg <= 22'((38'(cfg.spawn_x) * 38'(m0)) >> 16);
        vy_prod_reg <= 23'((39'(vy_mag) * 39'(m4)) >> 16);
        vz_prod_reg <= 24'((40'(vz_mag) * 40'({m5, 1'b0})) >> 16);
    end

    always_comb
    begin
        spawn.px = 32'(cfg.spawn_x) + apply_sign(32'(px_prod_reg), n0);
        spawn.py = 32'(cfg.spawn_y) + apply_sign(32'({m1, 3'b000}), n1);
        spawn.pz = {{8{cfg.spawn_z[23]}}, cfg.spawn_z} + apply_sign(32'({m2, 1'b0}), n2);
        spawn.vx = {{8{cfg.spawn_vx[23]}}, cfg.spawn_vx} + apply_sign(32'({m3, 1'b0}), n3);
        spawn.vy = apply_sign(32'(vy_prod_reg), vy_neg ^ n4);
        spawn.vz = apply_sign(32'(vz_prod_reg), vz_neg ^ n5);
    end

endmodule

// ===== hdl/particle_step_depth_plot_core.sv =====
// Top level: particle memory, depth/age store and the step sequencer.
//
// Input items arrive on s_tvalid/s_tready/s_tdata: cmd 0 clears the depth
// store, cmd 1 steps one particle and plots it, cmd 2 reads one store entry.
// Every item gives exactly one result on m_tvalid/m_tready/m_tdata.
// Items are handled one at a time: a step passes the load, move, address,
// plot and output states, a read the store-read and output states, clear and
// unused codes the output state alone; s_tready is low until the result is
// loaded. After the particle memory read at the accepting edge the step runs
// move, respawn select, address multiply with store read, compare-write and
// output load, one registered stage each.
// The result sits in an output register, so the next item is taken while a
// result waits; a stalled receiver holds the sequencer only when the next
// result is ready to be loaded.
// Reset loads the register defaults and runs a clearing pass over both
// memories before s_tready rises. Clears bump an epoch tag kept in each
// store entry; once every 255 clears the epoch wraps and the same pass runs
// on the store alone after that clear's result.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered in cfg_reg.
module particle_step_depth_plot_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cmd[1:0], particle_index[11:2], pixel_address[25:12],
    // random_low[89:26], random_high[121:90], zero fill above
    input  logic [psd_pkg::IN_W-1:0]        s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // depth_value[31:0], age_velocity[63:32], plot_address[77:64],
    // plotted[78], respawned[79]
    output logic [psd_pkg::OUT_W-1:0]       m_tdata,
    input  logic                            cfg_we,
    input  logic [psd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import psd_pkg::*;

    localparam logic [2:0] ST_SWEEP = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_MOVE  = 3'd3;
    localparam logic [2:0] ST_ADDR  = 3'd4;
    localparam logic [2:0] ST_PLOT  = 3'd5;
    localparam logic [2:0] ST_DREAD = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [31:0]        age;
        logic [31:0]        depth;
    } entry_t;

    typedef struct packed {
        logic        respawned;
        logic        plotted;
        logic [13:0] plot_address;
        logic [31:0] age_velocity;
        logic [31:0] depth_value;
    } result_t;

    function automatic particle_t step_motion(input particle_t p);
        particle_t q;
        q.px = p.px + p.vx;
        q.py = p.py + p.vy;
        q.pz = p.pz + p.vz;
        q.vx = p.vx - 32'($signed(p.vx) >>> 5);
        q.vy = p.vy - 32'($signed(p.vy) >>> 5) - GRAVITY;
        q.vz = p.vz - 32'($signed(p.vz) >>> 5);
        return q;
    endfunction

    function automatic logic on_map(input logic [31:0] px, input logic [31:0] py,
                                    input logic [7:0] w, input logic [7:0] h);
        logic [15:0] x;
        logic [15:0] y;
        x = px[31:16];
        y = py[31:16];
        return !x[15] && !y[15] && (x < {8'h00, w}) && (y < {8'h00, h});
    endfunction

    // input unpacking
    logic [1:0]  in_cmd;
    logic [9:0]  in_idx;
    logic [13:0] in_addr;
    logic [63:0] in_rlo;
    logic [31:0] in_rhi;

    assign in_cmd  = s_tdata[1:0];
    assign in_idx  = s_tdata[11:2];
    assign in_addr = s_tdata[25:12];
    assign in_rlo  = s_tdata[89:26];
    assign in_rhi  = s_tdata[121:90];

    logic [2:0]         state_reg, state_next;
    logic [SWEEP_W-1:0] sweep_cnt_reg;
    logic               clr_part_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic               wrap_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    result_t            res_reg;
    cfg_t               cfg_reg;

    logic [9:0]         idx_reg;
    logic [13:0]        addr_reg;
    logic [63:0]        rlo_reg;
    logic [31:0]        rhi_reg;

    particle_t          mv_reg;
    logic               slow_reg;
    particle_t          fin_reg;
    logic               resp_reg;
    logic [16:0]        pa_reg;
    logic               plot_ok_reg;

    logic               accept;
    logic               out_free;
    logic [7:0]         w_lim, h_lim;
    particle_t          moved;
    logic               slow;
    particle_t          spawn;
    particle_t          fin_p;
    logic               resp_now;
    logic               plot_ok;
    logic [16:0]        pa;
    logic [31:0]        stored;
    logic               plot_hit;
    logic               read_valid;

    // particle memory
    particle_t          pmem [PARTICLES];
    logic               pm_we;
    logic [PART_AW-1:0] pm_waddr, pm_raddr;
    particle_t          pm_wdata, pm_rdata_reg;

    // depth and age store with epoch tags
    entry_t              dmem [STORE_SIZE];
    logic                dm_we;
    logic [STORE_AW-1:0] dm_waddr, dm_raddr;
    entry_t              dm_wdata, dm_rdata_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    assign w_lim = (16'(cfg_reg.image_width) > 16'(MAX_WIDTH)) ? 8'(MAX_WIDTH)
                                                               : cfg_reg.image_width;
    assign h_lim = (16'(cfg_reg.image_height) > 16'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT)
                                                                 : cfg_reg.image_height;

    psd_respawn u_respawn (
        .clk     (clk),
        .cfg     (cfg_reg),
        .rand_lo (rlo_reg),
        .rand_hi (rhi_reg),
        .spawn   (spawn)
    );

    assign moved    = step_motion(pm_rdata_reg);
    assign slow     = $signed(pm_rdata_reg.vx) < SLOW_LIMIT;
    assign resp_now = slow_reg || !on_map(mv_reg.px, mv_reg.py, w_lim, h_lim);
    assign fin_p    = resp_now ? spawn : mv_reg;

    assign plot_ok  = !slow_reg && on_map(fin_reg.px, fin_reg.py, w_lim, h_lim);
    assign pa       = 17'(fin_reg.py[23:16]) * 17'(w_lim) + 17'(fin_reg.px[23:16]);

    assign stored     = (dm_rdata_reg.tag == epoch_reg) ? dm_rdata_reg.depth : 32'd0;
    assign plot_hit   = plot_ok_reg && ($signed(fin_reg.pz) > $signed(stored));
    assign read_valid = (32'(addr_reg) < STORE_SIZE) && (dm_rdata_reg.tag == epoch_reg);

    assign pm_raddr = PART_AW'(in_idx);

    always_comb
    begin
        state_next = state_reg;
        pm_we      = 1'b0;
        pm_waddr   = PART_AW'(idx_reg);
        pm_wdata   = fin_p;
        dm_we      = 1'b0;
        dm_waddr   = STORE_AW'(pa_reg);
        dm_wdata   = '{tag: epoch_reg, age: fin_reg.vx, depth: fin_reg.pz};
        dm_raddr   = STORE_AW'(in_addr);
        unique case (state_reg)
            ST_SWEEP:
            begin
                dm_we    = (32'(sweep_cnt_reg) < STORE_SIZE);
                dm_waddr = STORE_AW'(sweep_cnt_reg);
                dm_wdata = '0;
                pm_we    = clr_part_reg && (32'(sweep_cnt_reg) < PARTICLES);
                pm_waddr = PART_AW'(sweep_cnt_reg);
                pm_wdata = '0;
                if (sweep_cnt_reg == SWEEP_W'(SWEEP_LEN - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    priority if (in_cmd == CMD_STEP && 32'(in_idx) < PARTICLES)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (in_cmd == CMD_READ)
                    begin
                        state_next = ST_DREAD;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_MOVE;
            end
            ST_MOVE:
            begin
                pm_we      = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                dm_raddr   = STORE_AW'(pa);
                state_next = ST_PLOT;
            end
            ST_PLOT:
            begin
                dm_we      = plot_hit;
                state_next = ST_OUT;
            end
            ST_DREAD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = wrap_reg ? ST_SWEEP : ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            pmem[pm_waddr] <= pm_wdata;
        end
        pm_rdata_reg <= pmem[pm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dmem[dm_waddr] <= dm_wdata;
        end
        dm_rdata_reg <= dmem[dm_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_cnt_reg <= '0;
            clr_part_reg  <= 1'b1;
            epoch_reg     <= EPOCH_W'(1);
            wrap_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '{image_width: 8'd128, image_height: 8'd128,
                               spawn_x: 23'h060000, spawn_y: 23'h400000,
                               spawn_z: 24'h190000, spawn_vx: 24'h040000,
                               spawn_vy_gain: 24'h050000, spawn_vz_gain: 24'h010000};
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_SWEEP)
            begin
                if (state_next == ST_IDLE)
                begin
                    sweep_cnt_reg <= '0;
                    clr_part_reg  <= 1'b0;
                    epoch_reg     <= EPOCH_W'(1);
                    wrap_reg      <= 1'b0;
                end
                else
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + SWEEP_W'(1);
                end
            end

            if (accept && in_cmd == CMD_CLEAR)
            begin
                if (epoch_reg == EPOCH_MAX)
                begin
                    wrap_reg <= 1'b1;
                end
                else
                begin
                    epoch_reg <= epoch_reg + EPOCH_W'(1);
                end
            end

            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:   cfg_reg.image_width   <= cfg_data[7:0];
                    REG_IMAGE_HEIGHT:  cfg_reg.image_height  <= cfg_data[7:0];
                    REG_SPAWN_X:       cfg_reg.spawn_x       <= cfg_data[22:0];
                    REG_SPAWN_Y:       cfg_reg.spawn_y       <= cfg_data[22:0];
                    REG_SPAWN_Z:       cfg_reg.spawn_z       <= cfg_data;
                    REG_SPAWN_VX:      cfg_reg.spawn_vx      <= cfg_data;
                    REG_SPAWN_VY_GAIN: cfg_reg.spawn_vy_gain <= cfg_data;
                    REG_SPAWN_VZ_GAIN: cfg_reg.spawn_vz_gain <= cfg_data;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg  <= in_idx;
            addr_reg <= in_addr;
            rlo_reg  <= in_rlo;
            rhi_reg  <= in_rhi;
            res_reg  <= '0;
        end

        if (state_reg == ST_LOAD)
        begin
            mv_reg   <= moved;
            slow_reg <= slow;
        end

        if (state_reg == ST_MOVE)
        begin
            fin_reg  <= fin_p;
            resp_reg <= resp_now;
        end

        if (state_reg == ST_ADDR)
        begin
            pa_reg      <= pa;
            plot_ok_reg <= plot_ok;
        end

        if (state_reg == ST_PLOT)
        begin
            res_reg.depth_value  <= fin_reg.pz;
            res_reg.age_velocity <= fin_reg.vx;
            res_reg.plot_address <= plot_ok_reg ? pa_reg[13:0] : 14'd0;
            res_reg.plotted      <= plot_hit;
            res_reg.respawned    <= resp_reg;
        end

        if (state_reg == ST_DREAD)
        begin
            res_reg.depth_value  <= read_valid ? dm_rdata_reg.depth : 32'd0;
            res_reg.age_velocity <= read_valid ? dm_rdata_reg.age : 32'd0;
            res_reg.plot_address <= addr_reg;
            res_reg.plotted      <= read_valid;
            res_reg.respawned    <= 1'b0;
        end

        if (state_reg == ST_OUT && out_free)
        begin
            out_reg <= res_reg;
        end
    end

`ifndef SYNTHESIS
    a_pm_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        pm_we |-> (state_reg == ST_MOVE || state_reg == ST_SWEEP))
        else $error("particle memory written outside move or sweep");

    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (epoch_reg != '0))
        else $error("epoch zero would match swept entries");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result shown without passing the output state");

    a_plot_gate: assert property (@(posedge clk) disable iff (!rst_n)
        (dm_we && state_reg == ST_PLOT) |-> plot_ok_reg)
        else $error("store written for a particle off the map");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after taking an item");
`endif

endmodule

// ===== tb/sv/particle_step_depth_plot_core_tb.sv =====
// Self-checking testbench for the particle step and depth plot core.
`timescale 1ns / 1ps

module particle_step_depth_plot_core_tb;
    import psd_pkg::*;

    localparam int     CLK_HALF          = 5;
    localparam int     DRAIN_CYCLES      = 20;
    localparam int     HOLD_CYCLES       = 400;
    localparam int     SETTING_COUNT     = 8;
    localparam int     ITEMS_PER_SETTING = 31;
    localparam int     WRAP_CLEARS       = 260;
    localparam int     MAX_PRINTS        = 100;
    localparam longint TIMEOUT_NS        = 10_000_000;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        logic [9:0]  index;
        logic [13:0] addr;
        logic [63:0] rlo;
        logic [31:0] rhi;
    } plot_cmd_t;

    typedef struct {
        logic [31:0] depth;
        logic [31:0] age;
        logic [13:0] addr;
        logic        plotted;
        logic        respawned;
    } plot_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow of the block state
    cfg_t        cfg_shadow;
    particle_t   particles [PARTICLES];
    logic [31:0] depth_mem [STORE_SIZE];
    logic [31:0] age_mem [STORE_SIZE];
    bit          entry_valid [STORE_SIZE];
    bit          entry_touched [STORE_SIZE];
    logic [13:0] touched_addrs [$];

    plot_result_t expected_plot_results [$];
    int           mismatch_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    bit           hold_req;

    particle_step_depth_plot_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("particle_step_depth_plot_core_tb: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [31:0] asr(input logic [31:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [31:0] sext24(input logic [23:0] v);
        return {{8{v[23]}}, v};
    endfunction

    function automatic logic [31:0] with_sign(input logic [31:0] v, input logic neg);
        return neg ? 32'd0 - v : v;
    endfunction

    // signed gain times unsigned magnitude, >> 16 toward zero
    function automatic logic [31:0] gain_product(input logic [23:0] g, input logic [31:0] m);
        logic [63:0] mag;
        logic [63:0] prod;
        mag  = g[23] ? (64'h100_0000 - {40'd0, g}) : {40'd0, g};
        prod = (mag * {32'd0, m}) >> 16;
        return with_sign(prod[31:0], g[23]);
    endfunction

    function automatic particle_t respawned_particle(input logic [63:0] rlo,
                                                     input logic [31:0] rhi);
        logic [15:0] sl [6];
        logic [31:0] m [6];
        logic [63:0] prod;
        particle_t   q;
        sl[0] = rlo[15:0];
        sl[1] = rlo[31:16];
        sl[2] = rlo[47:32];
        sl[3] = rlo[63:48];
        sl[4] = rhi[15:0];
        sl[5] = rhi[31:16];
        for (int k = 0; k < 6; k++)
            m[k] = {17'd0, sl[k][14:0]};
        prod = ({41'd0, cfg_shadow.spawn_x} * {32'd0, m[0]}) >> 16;
        q.px = {9'd0, cfg_shadow.spawn_x} + with_sign(prod[31:0], sl[0][15]);
        q.py = {9'd0, cfg_shadow.spawn_y} + with_sign(m[1] << 3, sl[1][15]);
        q.pz = sext24(cfg_shadow.spawn_z) + with_sign(m[2] << 1, sl[2][15]);
        q.vx = sext24(cfg_shadow.spawn_vx) + with_sign(m[3] << 1, sl[3][15]);
        q.vy = with_sign(gain_product(cfg_shadow.spawn_vy_gain, m[4]), sl[4][15]);
        q.vz = with_sign(gain_product(cfg_shadow.spawn_vz_gain, m[5] << 1), sl[5][15]);
        return q;
    endfunction

    function automatic bit on_image(input logic [31:0] px, py, input int unsigned w, h);
        logic [31:0] col;
        logic [31:0] row;
        col = asr(px, 16);
        row = asr(py, 16);
        if (col[31] || row[31])
            return 1'b0;
        return (col < w) && (row < h);
    endfunction

    function automatic plot_result_t compute_plot_result(input plot_cmd_t c);
        plot_result_t r;
        particle_t    p;
        int unsigned  w;
        int unsigned  h;
        logic [31:0]  pa;
        logic [31:0]  stored;
        r = '{default: '0};
        w = (cfg_shadow.image_width > MAX_WIDTH) ? MAX_WIDTH : cfg_shadow.image_width;
        h = (cfg_shadow.image_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_shadow.image_height;
        case (c.cmd)
            CMD_CLEAR:
                entry_valid = '{default: 1'b0};
            CMD_READ:
            begin
                r.addr = c.addr;
                if (entry_valid[c.addr])
                begin
                    r.depth   = depth_mem[c.addr];
                    r.age     = age_mem[c.addr];
                    r.plotted = 1'b1;
                end
            end
            CMD_STEP:
            begin
                p = particles[c.index];
                if ($signed(p.vx) < SLOW_LIMIT)
                begin
                    // too slow to move: recreated in place, never plotted
                    p = respawned_particle(c.rlo, c.rhi);
                    r.respawned = 1'b1;
                end
                else
                begin
                    p.px = p.px + p.vx;
                    p.py = p.py + p.vy;
                    p.pz = p.pz + p.vz;
                    p.vx = p.vx - asr(p.vx, 5);
                    p.vy = p.vy - asr(p.vy, 5) - GRAVITY;
                    p.vz = p.vz - asr(p.vz, 5);
                    if (!on_image(p.px, p.py, w, h))
                    begin
                        p = respawned_particle(c.rlo, c.rhi);
                        r.respawned = 1'b1;
                    end
                    if (on_image(p.px, p.py, w, h))
                    begin
                        pa     = asr(p.py, 16) * w + asr(p.px, 16);
                        r.addr = pa[13:0];
                        // an invalid entry counts as depth zero
                        stored = entry_valid[pa[13:0]] ? depth_mem[pa[13:0]] : 32'd0;
                        if ($signed(p.pz) > $signed(stored))
                        begin
                            depth_mem[pa[13:0]]   = p.pz;
                            age_mem[pa[13:0]]     = p.vx;
                            entry_valid[pa[13:0]] = 1'b1;
                            r.plotted             = 1'b1;
                            if (!entry_touched[pa[13:0]])
                            begin
                                entry_touched[pa[13:0]] = 1'b1;
                                touched_addrs.push_back(pa[13:0]);
                            end
                        end
                    end
                end
                particles[c.index] = p;
                r.depth = p.pz;
                r.age   = p.vx;
            end
            default:
                ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic cfg_t config_setting(input int k);
        case (k)
            1: return '{image_width: 8'd4, image_height: 8'd3, spawn_x: 23'h010000,
                        spawn_y: 23'h020000, spawn_z: 24'h000000, spawn_vx: 24'h002000,
                        spawn_vy_gain: 24'h010000, spawn_vz_gain: 24'hFF0000};
            2: return '{image_width: 8'd128, image_height: 8'd128, spawn_x: 23'h7FFFFF,
                        spawn_y: 23'h7F0000, spawn_z: 24'h7FFFFF, spawn_vx: 24'h7FFFFF,
                        spawn_vy_gain: 24'h7FFFFF, spawn_vz_gain: 24'h7FFFFF};
            3: return '{image_width: 8'd1, image_height: 8'd1, spawn_x: 23'h000000,
                        spawn_y: 23'h000000, spawn_z: 24'h800000, spawn_vx: 24'h800000,
                        spawn_vy_gain: 24'h800000, spawn_vz_gain: 24'h800000};
            4: return '{image_width: 8'd255, image_height: 8'd200, spawn_x: 23'h200000,
                        spawn_y: 23'h100000, spawn_z: 24'h000100, spawn_vx: 24'h00C000,
                        spawn_vy_gain: 24'h0A0000, spawn_vz_gain: 24'h030000};
            5: return '{image_width: 8'd0, image_height: 8'd64, spawn_x: 23'h040000,
                        spawn_y: 23'h040000, spawn_z: 24'h010000, spawn_vx: 24'h020000,
                        spawn_vy_gain: 24'h010000, spawn_vz_gain: 24'h010000};
            6: return '{image_width: 8'd16, image_height: 8'd16, spawn_x: 23'h080000,
                        spawn_y: 23'h0C0000, spawn_z: 24'h010000, spawn_vx: 24'h008000,
                        spawn_vy_gain: 24'h020000, spawn_vz_gain: 24'h030000};
            // one-pixel image, vx right at the slow threshold
            7: return '{image_width: 8'd1, image_height: 8'd1, spawn_x: 23'h008000,
                        spawn_y: 23'h008000, spawn_z: 24'hFFF000, spawn_vx: 24'h001000,
                        spawn_vy_gain: 24'h000000, spawn_vz_gain: 24'h000001};
            default: return '{image_width: 8'd128, image_height: 8'd128, spawn_x: 23'h060000,
                              spawn_y: 23'h400000, spawn_z: 24'h190000, spawn_vx: 24'h040000,
                              spawn_vy_gain: 24'h050000, spawn_vz_gain: 24'h010000};
        endcase
    endfunction

    function automatic logic [15:0] pick_slice(input bit extreme);
        if (!extreme)
            return 16'($urandom);
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic plot_cmd_t random_fields(input logic [1:0] cmd);
        plot_cmd_t c;
        bit        extreme;
        extreme = ($urandom_range(7) == 0);
        c.cmd   = cmd;
        c.index = 10'($urandom_range(PARTICLES - 1));
        c.addr  = 14'($urandom_range(STORE_SIZE - 1));
        c.rlo   = {pick_slice(extreme), pick_slice(extreme),
                   pick_slice(extreme), pick_slice(extreme)};
        c.rhi   = {pick_slice(extreme), pick_slice(extreme)};
        return c;
    endfunction

    // a few hot particles so that each lives through many steps
    function automatic logic [9:0] pick_particle();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 75)
            return 10'($urandom_range(15));
        if (r < 85)
            return 10'($urandom_range(PARTICLES - 1));
        return 10'($urandom_range(PARTICLES - 1, PARTICLES - 16));
    endfunction

    function automatic plot_cmd_t step_item(input logic [9:0] idx);
        plot_cmd_t c;
        c = random_fields(CMD_STEP);
        c.index = idx;
        return c;
    endfunction

    // reads only target entries that have been plotted at least once
    function automatic plot_cmd_t read_item();
        plot_cmd_t c;
        if (touched_addrs.size() == 0)
            return step_item(pick_particle());
        c = random_fields(CMD_READ);
        c.addr = touched_addrs[$urandom_range(touched_addrs.size() - 1)];
        return c;
    endfunction

    function automatic plot_cmd_t random_item();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 72)
            return step_item(pick_particle());
        if (r < 90)
            return read_item();
        if (r < 95)
            return random_fields(CMD_CLEAR);
        return random_fields(CMD_UNUSED);
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t: %s mismatch: got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input plot_cmd_t c);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {6'd0, c.rhi, c.rlo, c.addr, c.index, c.cmd};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_plot_results.push_back(compute_plot_result(c));
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_plot_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_config(input cfg_t v);
        logic [CFG_DATA_W-1:0] vals [8];
        vals[REG_IMAGE_WIDTH]   = 24'(v.image_width);
        vals[REG_IMAGE_HEIGHT]  = 24'(v.image_height);
        vals[REG_SPAWN_X]       = 24'(v.spawn_x);
        vals[REG_SPAWN_Y]       = 24'(v.spawn_y);
        vals[REG_SPAWN_Z]       = v.spawn_z;
        vals[REG_SPAWN_VX]      = v.spawn_vx;
        vals[REG_SPAWN_VY_GAIN] = v.spawn_vy_gain;
        vals[REG_SPAWN_VZ_GAIN] = v.spawn_vz_gain;
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        cfg_shadow = v;
    endtask

    // receiver side: random stalls plus an occasional long hold-off
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        plot_result_t got;
        plot_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.depth     = m_tdata[31:0];
            got.age       = m_tdata[63:32];
            got.addr      = m_tdata[77:64];
            got.plotted   = m_tdata[78];
            got.respawned = m_tdata[79];
            if (expected_plot_results.size() == 0)
                report_mismatch("unexpected item", m_tdata[31:0], 32'd0);
            else
            begin
                want = expected_plot_results.pop_front();
                if (got.depth !== want.depth)
                    report_mismatch("depth_value", got.depth, want.depth);
                if (got.age !== want.age)
                    report_mismatch("age_velocity", got.age, want.age);
                if (got.addr !== want.addr)
                    report_mismatch("plot_address", 32'(got.addr), 32'(want.addr));
                if (got.plotted !== want.plotted)
                    report_mismatch("plotted", 32'(got.plotted), 32'(want.plotted));
                if (got.respawned !== want.respawned)
                    report_mismatch("respawned", 32'(got.respawned),
                                    32'(want.respawned));
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        plot_cmd_t c;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_config(config_setting(0));
        // fresh particle has zero vx: slow path
        c = step_item(10'd0);
        c.rlo = 64'd0;
        c.rhi = 32'd0;
        send_item(c);
        c = step_item(10'd1023);
        c.rlo = '1;
        c.rhi = '1;
        send_item(c);
        c = step_item(10'd1);
        c.rlo = {4{16'h7FFF}};
        c.rhi = {2{16'h7FFF}};
        send_item(c);
        c = step_item(10'd2);
        c.rlo = {4{16'h8000}};
        c.rhi = {2{16'h8000}};
        send_item(c);
        repeat (4)
        begin
            send_item(step_item(10'd0));
            send_item(step_item(10'd1));
        end
        send_item(read_item());
        send_item(read_item());
        c = random_fields(CMD_UNUSED);
        c.addr  = '1;
        c.index = '1;
        send_item(c);
        c = random_fields(CMD_CLEAR);
        c.addr  = '1;
        c.index = '1;
        send_item(c);
        // entries are stale after the clear
        send_item(read_item());
        send_item(step_item(10'd0));
        send_item(step_item(10'd1023));
        send_item(read_item());
        wait_for_results();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        repeat (40) send_item(random_item());
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int tx_idle, input int rx_idle);
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        for (int k = 0; k < SETTING_COUNT; k++)
        begin
            wait_for_results();
            write_config(config_setting(k));
            repeat (ITEMS_PER_SETTING) send_item(random_item());
        end
        wait_for_results();
    endtask

    // enough clears to wrap the store's epoch tag at least once
    task automatic test_clear_wrap();
        send_idle_pct = 10;
        recv_idle_pct = 10;
        write_config(config_setting(6));
        for (int i = 0; i < WRAP_CLEARS; i++)
        begin
            send_item(random_fields(CMD_CLEAR));
            if (i % 50 == 0)
            begin
                send_item(step_item(pick_particle()));
                send_item(read_item());
            end
        end
        repeat (20) send_item(random_item());
        wait_for_results();
    endtask

    initial
    begin
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        hold_req       = 1'b0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        rst_n          = 1'b0;
        cfg_shadow     = config_setting(0);
        particles      = '{default: '0};
        entry_valid    = '{default: 1'b0};
        entry_touched  = '{default: 1'b0};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random_traffic(19, 54);
        test_random_traffic(54, 19);
        test_random_traffic(0, 0);
        test_clear_wrap();

        wait_for_results();
        if (mismatch_count == 0)
            $display("particle_step_depth_plot_core_tb: PASS");
        else
            $display("particle_step_depth_plot_core_tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/psd_pkg.sv
hdl/psd_respawn.sv
hdl/particle_step_depth_plot_core.sv
tb/sv/particle_step_depth_plot_core_tb.sv
